// File: hw/rtl/rmts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmts_pkg
// Types and constants of the rate-monotonic task scheduler.
// ----------------------------------------------------------------------------
package rmts_pkg;

  localparam int ID_W     = 22;
  localparam int TIME_W   = 32;
  localparam int UTIL_W   = 14;
  localparam int AGE_W    = 8;
  localparam int STATUS_W = 3;
  localparam int TOTAL_W  = 16;
  localparam int PROD_W   = TIME_W + UTIL_W;
  localparam int DIV_STEPS = UTIL_W;

  localparam logic [UTIL_W-1:0] UTIL_SCALE      = 14'd10000;
  localparam logic [UTIL_W-1:0] UTIL_LIMIT_INIT = 14'd6930;

  typedef enum logic [1:0] {
    OP_REGISTER   = 2'd0,
    OP_YIELD      = 2'd1,
    OP_WAKE       = 2'd2,
    OP_DEREGISTER = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_REJECT   = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_INVALID  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    RS_SLEEP = 2'd0,
    RS_READY = 2'd1,
    RS_RUN   = 2'd2,
    RS_FRESH = 2'd3
  } run_state_t;

  // one table entry as stored in the task memory
  typedef struct packed {
    logic [ID_W-1:0]   task_id;
    logic [TIME_W-1:0] period;
    logic [UTIL_W-1:0] util;
    run_state_t        run_state;
    logic [TIME_W-1:0] pstart;
    logic [AGE_W-1:0]  age;
  } task_rec_t;

endpackage

// File: hw/rtl/rate_monotonic_task_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rate_monotonic_task_scheduler
// Periodic task table with utilization admission and rate-monotonic dispatch.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-------------------------------------
//  request   | in_valid / in_stall       | opcode, task_id, period_ms,
//            |                           | compute_ms, now_ms
//  result    | out_valid / out_stall     | status, utilization_total, sleep_ms,
//            |                           | slept, switched, running_valid,
//            |                           | running_id
//  config    | APB psel/penable/pwrite   | utilization_limit at byte address 0
//
// Register runs the 14-step divider and one memory pass and can be refused
// before the pass; yield and wake run a lookup pass, a dispatch pass, on a
// preemption the old-task read and write, and the new-task write when a task
// is switched in; deregister runs a lookup pass and a re-ageing pass.
// Reset clears the slot valid bits and the running marker and loads the limit
// with 6930; the memory itself is not cleared. While the result register is
// full and stalled, a finished request waits in its last state and no new one
// enters.
// ----------------------------------------------------------------------------
module rate_monotonic_task_scheduler #(
  parameter int MAX_TASKS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      opcode,
  input  logic [rmts_pkg::ID_W-1:0]       task_id,
  input  logic [rmts_pkg::TIME_W-1:0]     period_ms,
  input  logic [rmts_pkg::TIME_W-1:0]     compute_ms,
  input  logic [rmts_pkg::TIME_W-1:0]     now_ms,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rmts_pkg::STATUS_W-1:0]   status,
  output logic [rmts_pkg::TOTAL_W-1:0]    utilization_total,
  output logic [rmts_pkg::TIME_W-1:0]     sleep_ms,
  output logic                            slept,
  output logic                            switched,
  output logic                            running_valid,
  output logic [rmts_pkg::ID_W-1:0]       running_id
);
  import rmts_pkg::*;

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(MAX_TASKS);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_CHK, S_DIV, S_ADM_CHK, S_ADMIT, S_ADM_END, S_FIND,
    S_ACT, S_DISP, S_DSEL, S_OLD_RD, S_OLD_WR, S_NEW_WR, S_DEREG, S_DONE
  } state_t;

  state_t state;

  // task memory and its ports
  task_rec_t mem [MAX_TASKS];
  logic             mem_re;
  logic [IDX_W-1:0] mem_ra;
  task_rec_t        rd_data;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  task_rec_t        mem_wd;

  // control state
  logic [MAX_TASKS-1:0] used;
  logic [CNT_W-1:0]     used_count;
  logic [UTIL_W-1:0]    util_sum;
  logic [UTIL_W-1:0]    limit;
  logic                 cur_valid;
  logic [IDX_W-1:0]     cur_slot;
  logic [TIME_W-1:0]    cur_period;
  logic [ID_W-1:0]      cur_id;

  // request latch
  opcode_t           op_q;
  logic [ID_W-1:0]   id_q;
  logic [TIME_W-1:0] period_q;
  logic [TIME_W-1:0] compute_q;
  logic [TIME_W-1:0] now_q;

  // pass sequencing
  logic [CNT_W-1:0] cnt;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;
  logic             found;
  logic [IDX_W-1:0] best_idx;
  task_rec_t        best_rec;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  // divider
  logic [PROD_W-1:0] prod;
  logic [TIME_W-1:0] rem;
  logic [UTIL_W-1:0] quo;
  logic [3:0]        div_cnt;

  // result being built
  status_t           res_status;
  logic [TIME_W-1:0] res_sleep;
  logic              res_slept;
  logic              res_switched;

  logic              pass_rd;
  logic              pass_last;
  logic [TIME_W:0]   div_trial;
  logic              div_ge;
  logic [TIME_W-1:0] y_elapsed;
  logic              y_ok;
  logic              find_hit;
  logic              disp_hit;
  task_rec_t         new_rec;
  task_rec_t         act_rec;
  logic              act_we;

  assign pready   = 1'b1;
  assign prdata   = paddr[2] ? 32'd0 : {{(32-UTIL_W){1'b0}}, limit};
  assign in_stall = (state != S_IDLE);

  assign pass_rd   = (cnt < CNT_END);
  assign pass_last = rd_vld && (cnt == CNT_END);

  // one restoring division step: bring down the next dividend bit
  assign div_trial = {rem, prod[UTIL_W-1]};
  assign div_ge    = (div_trial >= {1'b0, period_q});

  // yield: time gone in the current period
  assign y_elapsed = (best_rec.run_state == RS_FRESH) ? '0 : (now_q - best_rec.pstart);
  assign y_ok      = (best_rec.period > y_elapsed);

  assign find_hit = rd_vld && used[rd_idx] && (rd_data.task_id == id_q) &&
                    (!found || (rd_data.age < best_rec.age));
  assign disp_hit = rd_vld && used[rd_idx] && (rd_data.run_state == RS_READY) &&
                    (!found || (rd_data.period < best_rec.period) ||
                     ((rd_data.period == best_rec.period) &&
                      (rd_data.age < best_rec.age)));

  always_comb begin
    new_rec           = '0;
    new_rec.task_id   = id_q;
    new_rec.period    = period_q;
    new_rec.util      = quo;
    new_rec.run_state = RS_FRESH;
    new_rec.pstart    = '0;
    new_rec.age       = '0;

    act_rec = best_rec;
    act_we  = 1'b0;
    if (op_q == OP_WAKE) begin
      act_rec.run_state = RS_READY;
      act_rec.pstart    = now_q;
      act_we            = 1'b1;
    end else if (op_q == OP_YIELD && y_ok && best_rec.run_state != RS_FRESH) begin
      act_rec.run_state = RS_SLEEP;
      act_we            = 1'b1;
    end
  end

  // memory port control
  always_comb begin
    mem_re = 1'b0;
    mem_ra = cnt[IDX_W-1:0];
    mem_we = 1'b0;
    mem_wa = rd_idx;
    mem_wd = rd_data;
    case (state)
      S_ADMIT: begin
        mem_re = pass_rd;
        if (rd_vld) begin
          if (used[rd_idx]) begin
            mem_we     = 1'b1;
            mem_wd.age = rd_data.age + AGE_W'(1);
          end else if (!free_found) begin
            mem_we = 1'b1;
            mem_wd = new_rec;
          end
        end
      end
      S_FIND, S_DISP: begin
        mem_re = pass_rd;
      end
      S_DEREG: begin
        mem_re = pass_rd;
        if (rd_vld && used[rd_idx] && rd_data.age > best_rec.age) begin
          mem_we     = 1'b1;
          mem_wd.age = rd_data.age - AGE_W'(1);
        end
      end
      S_ACT: begin
        mem_we = found && act_we;
        mem_wa = best_idx;
        mem_wd = act_rec;
      end
      S_OLD_RD: begin
        mem_re = 1'b1;
        mem_ra = cur_slot;
      end
      S_OLD_WR: begin
        // demote the preempted task only if it is still marked running
        mem_we           = (rd_data.run_state == RS_RUN);
        mem_wa           = cur_slot;
        mem_wd.run_state = RS_READY;
      end
      S_NEW_WR: begin
        mem_we           = 1'b1;
        mem_wa           = best_idx;
        mem_wd           = best_rec;
        mem_wd.run_state = RS_RUN;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= UTIL_LIMIT_INIT;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      limit <= pwdata[UTIL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used       <= '0;
      used_count <= '0;
      util_sum   <= '0;
      cur_valid  <= 1'b0;
      rd_vld     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      // shared pass sequencer: issue one read a cycle, track the last
      if (state == S_ADMIT || state == S_FIND || state == S_DISP ||
          state == S_DEREG) begin
        if (pass_rd) begin
          cnt    <= cnt + CNT_W'(1);
          rd_idx <= cnt[IDX_W-1:0];
        end
        rd_vld <= pass_rd;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q         <= opcode_t'(opcode);
            id_q         <= task_id;
            period_q     <= period_ms;
            compute_q    <= compute_ms;
            now_q        <= now_ms;
            res_status   <= ST_OK;
            res_sleep    <= '0;
            res_slept    <= 1'b0;
            res_switched <= 1'b0;
            cnt          <= '0;
            rd_vld       <= 1'b0;
            found        <= 1'b0;
            if (opcode_t'(opcode) != OP_REGISTER) begin
              state <= S_FIND;
            end else if (period_ms == '0) begin
              res_status <= ST_INVALID;
              state      <= S_DONE;
            end else if (used_count == CNT_END) begin
              res_status <= ST_FULL;
              state      <= S_DONE;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod  <= PROD_W'(compute_q) * PROD_W'(UTIL_SCALE);
          state <= S_CHK;
        end
        S_CHK: begin
          // a quotient of 2^14 or more cannot fit under any limit
          if (prod >= {period_q, {UTIL_W{1'b0}}}) begin
            res_status <= ST_REJECT;
            state      <= S_DONE;
          end else begin
            rem     <= prod[PROD_W-1:UTIL_W];
            prod    <= {{TIME_W{1'b0}}, prod[UTIL_W-1:0]};
            div_cnt <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          rem     <= div_ge ? TIME_W'(div_trial - {1'b0, period_q}) : div_trial[TIME_W-1:0];
          quo     <= {quo[UTIL_W-2:0], div_ge};
          prod    <= {prod[PROD_W-2:0], 1'b0};
          div_cnt <= div_cnt + 4'd1;
          if (div_cnt == 4'(DIV_STEPS - 1)) begin
            state <= S_ADM_CHK;
          end
        end
        S_ADM_CHK: begin
          if (({1'b0, util_sum} + {1'b0, quo}) > {1'b0, limit}) begin
            res_status <= ST_REJECT;
            state      <= S_DONE;
          end else begin
            cnt        <= '0;
            rd_vld     <= 1'b0;
            free_found <= 1'b0;
            state      <= S_ADMIT;
          end
        end
        S_ADMIT: begin
          // age every live entry, drop the new one into the first free slot
          if (rd_vld && !used[rd_idx] && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= rd_idx;
          end
          if (pass_last) begin
            state <= S_ADM_END;
          end
        end
        S_ADM_END: begin
          used[free_idx] <= 1'b1;
          used_count     <= used_count + CNT_W'(1);
          util_sum       <= util_sum + quo;
          state          <= S_DONE;
        end
        S_FIND: begin
          if (find_hit) begin
            found    <= 1'b1;
            best_idx <= rd_idx;
            best_rec <= rd_data;
          end
          if (pass_last) begin
            state <= S_ACT;
          end
        end
        S_ACT: begin
          cnt    <= '0;
          rd_vld <= 1'b0;
          if (!found) begin
            res_status <= ST_NOTFOUND;
            state      <= S_DONE;
          end else if (op_q == OP_DEREGISTER) begin
            used[best_idx] <= 1'b0;
            used_count     <= used_count - CNT_W'(1);
            util_sum       <= util_sum - best_rec.util;
            if (cur_valid && cur_slot == best_idx) begin
              cur_valid <= 1'b0;
            end
            state <= S_DEREG;
          end else begin
            if (op_q == OP_YIELD && y_ok) begin
              res_sleep <= best_rec.period - y_elapsed;
              res_slept <= 1'b1;
              if (cur_valid && cur_slot == best_idx) begin
                cur_valid <= 1'b0;
              end
            end
            found <= 1'b0;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          if (disp_hit) begin
            found    <= 1'b1;
            best_idx <= rd_idx;
            best_rec <= rd_data;
          end
          if (pass_last) begin
            state <= S_DSEL;
          end
        end
        S_DSEL: begin
          if (!found) begin
            state <= S_DONE;
          end else if (cur_valid) begin
            state <= (best_rec.period < cur_period) ? S_OLD_RD : S_DONE;
          end else begin
            state <= S_NEW_WR;
          end
        end
        S_OLD_RD: begin
          state <= S_OLD_WR;
        end
        S_OLD_WR: begin
          state <= S_NEW_WR;
        end
        S_NEW_WR: begin
          cur_valid    <= 1'b1;
          cur_slot     <= best_idx;
          cur_period   <= best_rec.period;
          cur_id       <= best_rec.task_id;
          res_switched <= 1'b1;
          state        <= S_DONE;
        end
        S_DEREG: begin
          if (pass_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the result register is free
          if (!out_valid || !out_stall) begin
            out_valid         <= 1'b1;
            status            <= res_status;
            utilization_total <= TOTAL_W'(util_sum);
            sleep_ms          <= res_sleep;
            slept             <= res_slept;
            switched          <= res_switched;
            running_valid     <= cur_valid;
            running_id        <= cur_valid ? cur_id : '0;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    used_count == CNT_W'($countones(used)))
    else $error("used_count out of step with valid bits");

  a_running_live: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> used[cur_slot])
    else $error("running marker points at a free slot");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state != S_IDLE))
    else $error("request accepted but sequencer stayed idle");

  a_util_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADM_END) |=> (util_sum == $past(util_sum) + $past(quo)))
    else $error("admission did not add the new term");
`endif

endmodule

// File: tb/sv/tb_rate_monotonic_task_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rate_monotonic_task_scheduler
// Self-checking bench for the rate-monotonic task scheduler.
// ----------------------------------------------------------------------------
// A short table of directed requests runs first, then random request mixes
// under several admission limits written over the APB port. Every accepted
// request goes through a task-table model held in the bench; each result
// transaction is compared field by field with the oldest predicted result.
// The request side sends in bursts, the result side stalls on its own
// pattern and once holds off for a long stretch so the block backs up.
// ----------------------------------------------------------------------------
module tb_rate_monotonic_task_scheduler;
  import rmts_pkg::*;

  localparam int NTASK      = 16;
  localparam int CYCLE_CAP  = 400000;
  localparam int DRAIN_WAIT = 100;
  localparam logic [2:0] ADDR_UTIL_LIMIT = 3'd0;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TOTAL_W-1:0]  total;
    logic [TIME_W-1:0]   sleep;
    logic                slept;
    logic                switched;
    logic                run_valid;
    logic [ID_W-1:0]     run_id;
  } sched_result_t;

  typedef struct packed {
    opcode_t           op;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] compute;
    logic [TIME_W-1:0] now;
  } sched_req_t;

  typedef struct {
    sched_req_t    req;
    bit            typed;   // expected result given in the row
    sched_result_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] opcode = '0;
  logic [ID_W-1:0] task_id = '0;
  logic [TIME_W-1:0] period_ms = '0, compute_ms = '0, now_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [TOTAL_W-1:0] utilization_total;
  logic [TIME_W-1:0] sleep_ms;
  logic slept, switched, running_valid;
  logic [ID_W-1:0] running_id;

  rate_monotonic_task_scheduler #(.MAX_TASKS(NTASK)) u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
    .task_id(task_id), .period_ms(period_ms), .compute_ms(compute_ms),
    .now_ms(now_ms),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .utilization_total(utilization_total), .sleep_ms(sleep_ms),
    .slept(slept), .switched(switched), .running_valid(running_valid),
    .running_id(running_id)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Task-table model: mirrors the slot table, the running marker and the
  // admission limit of the block.
  // --------------------------------------------------------------------------
  logic [UTIL_W-1:0] m_limit;
  bit                m_used   [NTASK];
  logic [ID_W-1:0]   m_id     [NTASK];
  logic [TIME_W-1:0] m_period [NTASK];
  logic [UTIL_W-1:0] m_term   [NTASK];
  run_state_t        m_state  [NTASK];
  logic [TIME_W-1:0] m_pstart [NTASK];
  int unsigned       m_age    [NTASK];
  bit                m_cur_valid;
  int                m_cur;

  sched_result_t expected_results[$];
  int            mismatches = 0;
  longint        cycles = 0;
  bit            long_hold_done = 1'b0;
  logic [TIME_W-1:0] clock_now = '0;

  function automatic longint unsigned util_total();
    longint unsigned s;
    s = 0;
    for (int i = 0; i < NTASK; i++)
      if (m_used[i]) s += m_term[i];
    return s;
  endfunction

  // Newest used slot carrying this id, or -1.
  function automatic int lookup_task(logic [ID_W-1:0] id);
    int best;
    best = -1;
    for (int i = 0; i < NTASK; i++)
      if (m_used[i] && m_id[i] == id && (best < 0 || m_age[i] < m_age[best]))
        best = i;
    return best;
  endfunction

  // Pick the ready task with the shortest period; preempt only if strictly
  // shorter than the running one.
  function automatic bit dispatch_ready();
    int nw;
    nw = -1;
    for (int i = 0; i < NTASK; i++)
      if (m_used[i] && m_state[i] == RS_READY &&
          (nw < 0 || m_period[i] < m_period[nw] ||
           (m_period[i] == m_period[nw] && m_age[i] < m_age[nw])))
        nw = i;
    if (nw < 0) return 1'b0;
    if (m_cur_valid) begin
      if (m_period[nw] >= m_period[m_cur]) return 1'b0;
      if (m_state[m_cur] == RS_RUN) m_state[m_cur] = RS_READY;
    end
    m_state[nw] = RS_RUN;
    m_cur = nw;
    m_cur_valid = 1'b1;
    return 1'b1;
  endfunction

  function automatic sched_result_t schedule_request(sched_req_t r);
    sched_result_t     res;
    int                free_slot, s;
    longint unsigned   term, tot;
    logic [TIME_W-1:0] elapsed;
    res = '0;
    res.status = ST_OK;
    if (r.op == OP_REGISTER) begin
      free_slot = -1;
      for (int i = 0; i < NTASK; i++)
        if (!m_used[i] && free_slot < 0) free_slot = i;
      if (r.period == 0) res.status = ST_INVALID;
      else if (free_slot < 0) res.status = ST_FULL;
      else begin
        term = (64'd10000 * r.compute) / r.period;
        if (util_total() + term > m_limit) res.status = ST_REJECT;
        else begin
          for (int i = 0; i < NTASK; i++)
            if (m_used[i]) m_age[i]++;
          m_used[free_slot]   = 1'b1;
          m_id[free_slot]     = r.id;
          m_period[free_slot] = r.period;
          m_term[free_slot]   = term[UTIL_W-1:0];
          m_state[free_slot]  = RS_FRESH;
          m_pstart[free_slot] = '0;
          m_age[free_slot]    = 0;
        end
      end
    end else begin
      s = lookup_task(r.id);
      if (s < 0) res.status = ST_NOTFOUND;
      else if (r.op == OP_YIELD) begin
        elapsed = (m_state[s] == RS_FRESH) ? '0 : r.now - m_pstart[s];
        if (m_period[s] > elapsed) begin
          res.sleep = m_period[s] - elapsed;
          res.slept = 1'b1;
          if (m_state[s] != RS_FRESH) m_state[s] = RS_SLEEP;
          if (m_cur_valid && m_cur == s) m_cur_valid = 1'b0;
        end
        res.switched = dispatch_ready();
      end else if (r.op == OP_WAKE) begin
        m_state[s]  = RS_READY;
        m_pstart[s] = r.now;
        res.switched = dispatch_ready();
      end else begin
        for (int i = 0; i < NTASK; i++)
          if (m_used[i] && m_age[i] > m_age[s]) m_age[i]--;
        m_used[s] = 1'b0;
        if (m_cur_valid && m_cur == s) m_cur_valid = 1'b0;
      end
    end
    tot = util_total();
    res.total     = (tot > 65535) ? 16'hFFFF : tot[TOTAL_W-1:0];
    res.run_valid = m_cur_valid;
    res.run_id    = m_cur_valid ? m_id[m_cur] : '0;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Offer one request and hold it until the block takes it; valid stays high
  // so a following request in the same burst goes out back to back.
  task automatic send_request(sched_req_t r, bit typed, sched_result_t typed_res);
    sched_result_t pred;
    in_valid   <= 1'b1;
    opcode     <= r.op;
    task_id    <= r.id;
    period_ms  <= r.period;
    compute_ms <= r.compute;
    now_ms     <= r.now;
    do @(posedge clk); while (in_stall);
    pred = schedule_request(r);
    expected_results.push_back(typed ? typed_res : pred);
  endtask

  task automatic idle_cycles(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Write the admission limit once nothing is in flight.
  task automatic write_limit(logic [31:0] v);
    in_valid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (60) @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_UTIL_LIMIT; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    m_limit = v[UTIL_W-1:0];
  endtask

  function automatic sched_req_t random_request();
    sched_req_t r;
    int         k;
    k = $urandom_range(0, 99);
    r.op = (k < 30) ? OP_REGISTER : (k < 55) ? OP_YIELD : (k < 85) ? OP_WAKE
                                                                   : OP_DEREGISTER;
    k = $urandom_range(0, 99);
    if (k < 80)      r.id = ID_W'($urandom_range(0, 5));
    else if (k < 88) r.id = {ID_W{1'b1}};
    else             r.id = ID_W'($urandom());
    k = $urandom_range(0, 99);
    if (k < 72)      r.period = $urandom_range(1, 200);
    else if (k < 80) r.period = '0;
    else if (k < 90) r.period = $urandom();
    else             r.period = 32'hFFFF_FFF0 | $urandom_range(0, 15);
    k = $urandom_range(0, 99);
    if (k < 40)      r.compute = '0;
    else if (k < 85) r.compute = $urandom_range(0, 12);
    else             r.compute = $urandom();
    clock_now += $urandom_range(0, 60);
    r.now = ($urandom_range(0, 9) == 0) ? $urandom() : clock_now;
    return r;
  endfunction

  task automatic random_phase(int n);
    int left;
    left = n;
    while (left > 0) begin
      int burst;
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && left > 0; b++, left--)
        send_request(random_request(), 1'b0, '0);
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 50));
    end
  endtask

  dir_row_t dir_rows[$];

  function automatic dir_row_t row(opcode_t op, logic [ID_W-1:0] id,
                                   logic [TIME_W-1:0] per, logic [TIME_W-1:0] cmp,
                                   logic [TIME_W-1:0] now, bit typed = 1'b0,
                                   sched_result_t res = '0);
    dir_row_t d;
    d.req   = '{op, id, per, cmp, now};
    d.typed = typed;
    d.res   = res;
    return d;
  endfunction

  initial begin
    m_limit = UTIL_LIMIT_INIT;
    for (int i = 0; i < NTASK; i++) m_used[i] = 1'b0;
    m_cur_valid = 1'b0;
    m_cur = 0;

    // Empty-table lookups, invalid period, rejection, then a small task set
    // walked through wake, preemption, late and early yields, wrap of the
    // period clock, duplicate ids and deregistering the running task.
    dir_rows.push_back(row(OP_YIELD, 22'd5, 0, 0, 0, 1'b1, '{ST_NOTFOUND, 0, 0, 0, 0, 0, 0}));
    dir_rows.push_back(row(OP_WAKE, 22'h3FFFFF, 0, 0, 0, 1'b1,
                           '{ST_NOTFOUND, 0, 0, 0, 0, 0, 0}));
    dir_rows.push_back(row(OP_DEREGISTER, 22'd0, 0, 0, 0, 1'b1,
                           '{ST_NOTFOUND, 0, 0, 0, 0, 0, 0}));
    dir_rows.push_back(row(OP_REGISTER, 22'd1, 0, 5, 0, 1'b1, '{ST_INVALID, 0, 0, 0, 0, 0, 0}));
    dir_rows.push_back(row(OP_REGISTER, 22'd1, 100, 32'hFFFF_FFFF, 0, 1'b1,
                           '{ST_REJECT, 0, 0, 0, 0, 0, 0}));
    dir_rows.push_back(row(OP_REGISTER, 22'd1, 100, 20, 0, 1'b1,
                           '{ST_OK, 2000, 0, 0, 0, 0, 0}));
    dir_rows.push_back(row(OP_REGISTER, 22'h3FFFFF, 32'hFFFF_FFFF, 0, 0, 1'b1,
                           '{ST_OK, 2000, 0, 0, 0, 0, 0}));
    dir_rows.push_back(row(OP_WAKE, 22'd1, 0, 0, 1000, 1'b1, '{ST_OK, 2000, 0, 0, 1, 1, 1}));
    dir_rows.push_back(row(OP_WAKE, 22'h3FFFFF, 0, 0, 0));
    dir_rows.push_back(row(OP_REGISTER, 22'd2, 50, 10, 0));
    dir_rows.push_back(row(OP_WAKE, 22'd2, 0, 0, 1010));
    dir_rows.push_back(row(OP_YIELD, 22'd2, 0, 0, 1030));
    dir_rows.push_back(row(OP_YIELD, 22'd1, 0, 0, 1200));
    dir_rows.push_back(row(OP_REGISTER, 22'd1, 10, 1, 0));
    dir_rows.push_back(row(OP_YIELD, 22'd1, 0, 0, 5));
    dir_rows.push_back(row(OP_WAKE, 22'd1, 0, 0, 32'hFFFF_FFF0));
    dir_rows.push_back(row(OP_YIELD, 22'd1, 0, 0, 3));
    dir_rows.push_back(row(OP_WAKE, 22'd1, 0, 0, 32'hFFFF_FFFF));
    dir_rows.push_back(row(OP_DEREGISTER, 22'd1, 0, 0, 0));
    dir_rows.push_back(row(OP_REGISTER, 22'd7, 1, 1, 0));
    dir_rows.push_back(row(OP_YIELD, 22'h3FFFFF, 0, 0, 32'hFFFF_FFFF));
    dir_rows.push_back(row(OP_DEREGISTER, 22'd1, 0, 0, 0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
      if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 20));
    end

    // Admission limit at its top value: the table fills up.
    write_limit(32'h3FFF);
    random_phase(120);
    // Zero limit: only zero-cost tasks get in.
    write_limit(32'd0);
    random_phase(80);
    write_limit(32'd10000);
    random_phase(100);
    write_limit($urandom_range(0, 16383));
    random_phase(100);

    in_valid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("** rate_monotonic_task_scheduler: PASSED **");
    else
      $display("** rate_monotonic_task_scheduler: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: stall pattern whose mode is picked at random from four, plus one
  // long hold-off so the block fills and backs up the request side.
  // --------------------------------------------------------------------------
  initial begin
    int mode, hold;
    mode = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (cycles % 64 == 0) mode = $urandom_range(0, 3);
      if (!long_hold_done && cycles == 3000) begin
        hold = 600;
        long_hold_done = 1'b1;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Compare each accepted result transaction with the oldest prediction.
  always @(posedge clk) begin
    sched_result_t got, want;
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      got = '{status, utilization_total, sleep_ms, slept, switched,
              running_valid, running_id};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transaction: %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch\n  expected %p\n  actual   %p", want, got);
        end
      end
    end
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("** rate_monotonic_task_scheduler: FAILED **");
      $finish;
    end
  end

endmodule
